// ===== rtl/rgbpal_pkg.sv =====
package rgbpal_pkg;

   localparam int PALETTE_SIZE = 256;
   localparam int COUNT_W      = $clog2(PALETTE_SIZE + 1);
   localparam int CHAN_W       = 8;
   localparam int COLOR_W      = 15;
   localparam int INDEX_W      = 8;
   localparam int FIELD_W      = 5;

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [INDEX_W-1:0] index_type;

   typedef struct packed {
      logic      busy;
      color_type color;
      logic      resolved;
      logic      added;
      index_type index;
   } token_type;

   function automatic color_type pack555(input logic [CHAN_W-1:0] red,
                                         input logic [CHAN_W-1:0] green,
                                         input logic [CHAN_W-1:0] blue);
      pack555 = {blue[CHAN_W-1 -: FIELD_W], green[CHAN_W-1 -: FIELD_W],
                 red[CHAN_W-1 -: FIELD_W]};
   endfunction

endpackage

// ===== rtl/rgbpal_cell.sv =====
module rgbpal_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  rgbpal_pkg::count_type palette_count,
   input  rgbpal_pkg::count_type cell_index,
   input  rgbpal_pkg::token_type prev_tok,
   output rgbpal_pkg::token_type next_tok
);
   import rgbpal_pkg::*;

   color_type entry_ff;
   token_type tok_ff;
   token_type tok_in;
   logic      write_en;

   always_comb begin
      tok_in   = prev_tok;
      write_en = 1'b0;
      if (prev_tok.busy && !prev_tok.resolved) begin
         if (cell_index == palette_count) begin
            // first free slot: append the color here
            write_en        = 1'b1;
            tok_in.resolved = 1'b1;
            tok_in.added    = 1'b1;
            tok_in.index    = INDEX_W'(cell_index);
         end else if (entry_ff == prev_tok.color) begin
            tok_in.resolved = 1'b1;
            tok_in.index    = INDEX_W'(cell_index);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && write_en) begin
         entry_ff <= prev_tok.color;
      end
   end

   assign next_tok = tok_ff;

endmodule

// ===== rtl/rgb555_palette_indexer_top.sv =====
// each pixel walks the row of palette cells, one cell per cycle while the row is not held
// by rsp_stall; only one pixel is in the row at a time, and the next is taken once the
// previous one has left the row into the result register
// a new pixel is taken while the previous result still waits on rsp_stall
// reset (synchronous, active high) empties the palette and the cell row
module rgb555_palette_indexer_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rgbpal_pkg::CHAN_W-1:0] req_red,
   input  logic [rgbpal_pkg::CHAN_W-1:0] req_green,
   input  logic [rgbpal_pkg::CHAN_W-1:0] req_blue,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output rgbpal_pkg::index_type        rsp_color_index,
   output rgbpal_pkg::color_type        rsp_packed_color,
   output logic                         rsp_newly_added,
   output logic                         rsp_overflow
);
   import rgbpal_pkg::*;

   token_type links [0:PALETTE_SIZE];
   token_type head_tok;
   token_type exit_tok;

   logic      in_flight_ff;
   logic      in_flight_in;
   count_type count_ff;
   count_type count_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   index_type rsp_index_ff;
   color_type rsp_color_ff;
   logic      rsp_added_ff;
   logic      rsp_overflow_ff;

   logic      accept;
   logic      out_load;
   logic      advance;

   assign accept    = req_valid && !req_stall;
   assign req_stall = in_flight_ff;

   always_comb begin
      head_tok          = '0;
      head_tok.busy     = accept;
      head_tok.color    = pack555(req_red, req_green, req_blue);
   end

   assign links[0] = head_tok;
   assign exit_tok = links[PALETTE_SIZE];

   genvar gi;
   generate
      for (gi = 0; gi < PALETTE_SIZE; gi++) begin : g_cell
         rgbpal_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .advance       (advance),
            .palette_count (count_ff),
            .cell_index    (COUNT_W'(gi)),
            .prev_tok      (links[gi]),
            .next_tok      (links[gi+1])
         );
      end
   endgenerate

   // hold the row while a finished result cannot leave
   assign out_load = exit_tok.busy && (!rsp_valid_ff || !rsp_stall);
   assign advance  = !(exit_tok.busy && rsp_valid_ff && rsp_stall);

   always_comb begin
      in_flight_in = in_flight_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         in_flight_in = 1'b1;
      end
      if (out_load) begin
         in_flight_in = 1'b0;
         if (exit_tok.added) begin
            count_in = count_ff + COUNT_W'(1);
         end
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_flight_ff <= in_flight_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_index_ff    <= exit_tok.resolved ? exit_tok.index : '0;
         rsp_color_ff    <= exit_tok.color;
         rsp_added_ff    <= exit_tok.added;
         rsp_overflow_ff <= !exit_tok.resolved;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_color_index  = rsp_index_ff;
   assign rsp_packed_color = rsp_color_ff;
   assign rsp_newly_added  = rsp_added_ff;
   assign rsp_overflow     = rsp_overflow_ff;

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rgbpal_pkg::*;

   localparam int GREEN_SHIFT   = 5;
   localparam int BLUE_SHIFT    = 10;
   localparam int RANDOM_PIXELS = 1330;
   localparam int CALM_FIRST    = 150;
   localparam int CALM_LAST     = 299;
   localparam int DRAIN_AT      = 700;
   localparam int REUSE_PERCENT = 55;
   localparam int CYCLE_LIMIT   = 10_000_000;
   localparam int DRAIN_CYCLES  = PALETTE_SIZE + 17;
   localparam int REPORT_LIMIT  = 10;

   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      index_type color_index;
      color_type packed_color;
      logic      newly_added;
      logic      overflow;
   } palette_result_type;

   typedef struct packed {
      chan_type           red;
      chan_type           green;
      chan_type           blue;
      logic               typed;
      palette_result_type result;
   } pixel_row_type;

   localparam int DIRECTED_ROWS = 20;
   localparam pixel_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0, 15'h0000, 1'b1, 1'b0}},
      '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd1, 15'h7FFF, 1'b1, 1'b0}},
      '{8'd7,   8'd7,   8'd7,   1'b1, '{8'd0, 15'h0000, 1'b0, 1'b0}},
      '{8'd248, 8'd248, 8'd248, 1'b1, '{8'd1, 15'h7FFF, 1'b0, 1'b0}},
      '{8'd255, 8'd0,   8'd0,   1'b1, '{8'd2, 15'h001F, 1'b1, 1'b0}},
      '{8'd0,   8'd255, 8'd0,   1'b1, '{8'd3, 15'h03E0, 1'b1, 1'b0}},
      '{8'd0,   8'd0,   8'd255, 1'b1, '{8'd4, 15'h7C00, 1'b1, 1'b0}},
      '{8'd8,   8'd0,   8'd0,   1'b1, '{8'd5, 15'h0001, 1'b1, 1'b0}},
      '{8'd0,   8'd8,   8'd0,   1'b1, '{8'd6, 15'h0020, 1'b1, 1'b0}},
      '{8'd0,   8'd0,   8'd8,   1'b1, '{8'd7, 15'h0400, 1'b1, 1'b0}},
      '{8'd128, 8'd128, 8'd128, 1'b1, '{8'd8, 15'h4210, 1'b1, 1'b0}},
      '{8'd135, 8'd132, 8'd129, 1'b1, '{8'd8, 15'h4210, 1'b0, 1'b0}},
      '{8'd255, 8'd0,   8'd0,   1'b1, '{8'd2, 15'h001F, 1'b0, 1'b0}},
      '{8'd170, 8'd85,  8'd51,  1'b0, '0},
      '{8'd85,  8'd170, 8'd204, 1'b0, '0},
      '{8'd171, 8'd87,  8'd55,  1'b0, '0},
      '{8'd1,   8'd2,   8'd4,   1'b0, '0},
      '{8'd247, 8'd247, 8'd247, 1'b0, '0},
      '{8'd0,   8'd255, 8'd255, 1'b0, '0},
      '{8'd255, 8'd255, 8'd0,   1'b0, '0}
   };

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   chan_type  req_red;
   chan_type  req_green;
   chan_type  req_blue;
   logic      rsp_valid;
   logic      rsp_stall;
   index_type rsp_color_index;
   color_type rsp_packed_color;
   logic      rsp_newly_added;
   logic      rsp_overflow;

   color_type          palette_copy [PALETTE_SIZE];
   int                 palette_fill = 0;
   palette_result_type pending_results [$];
   int                 failures = 0;
   int                 cycle_count = 0;

   rgb555_palette_indexer_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_color_index  (rsp_color_index),
      .rsp_packed_color (rsp_packed_color),
      .rsp_newly_added  (rsp_newly_added),
      .rsp_overflow     (rsp_overflow)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic palette_result_type lookup_or_append(input chan_type red,
                                                           input chan_type green,
                                                           input chan_type blue);
      palette_result_type res;
      color_type          color;
      int                 hit;
      color = (color_type'(blue >> 3) << BLUE_SHIFT) | (color_type'(green >> 3) << GREEN_SHIFT)
              | color_type'(red >> 3);
      hit = -1;
      for (int i = 0; i < palette_fill; i++) begin
         if (hit < 0 && palette_copy[i] == color) begin
            hit = i;
         end
      end
      res.packed_color = color;
      res.newly_added  = 1'b0;
      res.overflow     = 1'b0;
      if (hit >= 0) begin
         res.color_index = index_type'(hit);
      end else if (palette_fill < PALETTE_SIZE) begin
         res.color_index = index_type'(palette_fill);
         res.newly_added = 1'b1;
         palette_copy[palette_fill] = color;
         palette_fill++;
      end else begin
         res.color_index = '0;
         res.overflow    = 1'b1;
      end
      return res;
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) begin
         return 1 + $urandom_range(3);
      end else if (pick < 95) begin
         return 5 + $urandom_range(15);
      end
      return 40 + $urandom_range(260);
   endfunction

   task automatic send_pixel(input chan_type red, input chan_type green, input chan_type blue,
                             input logic typed, input palette_result_type typed_result,
                             input int gap);
      palette_result_type predicted;
      req_valid <= 1'b1;
      req_red   <= red;
      req_green <= green;
      req_blue  <= blue;
      do @(posedge clock); while (req_stall);
      predicted = lookup_or_append(red, green, blue);
      pending_results = {pending_results, (typed ? typed_result : predicted)};
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : pixel_source
      chan_type  red;
      chan_type  green;
      chan_type  blue;
      color_type pick;
      int        gap;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_red   <= '0;
      req_green <= '0;
      req_blue  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         gap = ($urandom_range(1) == 0) ? 0 : gap_length();
         send_pixel(DIRECTED[i].red, DIRECTED[i].green, DIRECTED[i].blue,
                    DIRECTED[i].typed, DIRECTED[i].result, gap);
      end

      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         if (n == DRAIN_AT) begin
            req_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         if (palette_fill > 0 && $urandom_range(99) < REUSE_PERCENT) begin
            // known color with fresh low bits, must hit
            pick  = palette_copy[$urandom_range(palette_fill - 1)];
            red   = {pick[GREEN_SHIFT-1:0], 3'($urandom_range(7))};
            green = {pick[BLUE_SHIFT-1:GREEN_SHIFT], 3'($urandom_range(7))};
            blue  = {pick[COLOR_W-1:BLUE_SHIFT], 3'($urandom_range(7))};
         end else begin
            red   = chan_type'($urandom);
            green = chan_type'($urandom);
            blue  = chan_type'($urandom);
         end
         if ((n >= CALM_FIRST && n <= CALM_LAST) || $urandom_range(1) == 0) begin
            gap = 0;
         end else begin
            gap = gap_length();
         end
         send_pixel(red, green, blue, 1'b0, '0, gap);
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : result_sink
      palette_result_type want;
      int                 stall_left;
      int                 calm_left;
      bit                 calm;
      stall_left = 0;
      calm_left  = 0;
      calm       = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               note_failure($sformatf("result with nothing pending: index %0d color %h",
                                      rsp_color_index, rsp_packed_color));
            end else begin
               want = pending_results.pop_front();
               if (want.color_index !== rsp_color_index
                   || want.packed_color !== rsp_packed_color
                   || want.newly_added !== rsp_newly_added
                   || want.overflow !== rsp_overflow) begin
                  note_failure($sformatf(
                     "expected index %0d color %h added %b overflow %b, got %0d %h %b %b",
                     want.color_index, want.packed_color, want.newly_added, want.overflow,
                     rsp_color_index, rsp_packed_color, rsp_newly_added, rsp_overflow));
               end
            end
         end
         // mix stretches of random stalls with stretches without any, chosen at random
         if (calm_left == 0) begin
            calm      = ($urandom_range(3) == 0);
            calm_left = 200 + $urandom_range(2000);
         end else begin
            calm_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(99) < 8) begin
            stall_left = gap_length() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

endmodule
